### hw/rtl/rmth_pkg.sv
// shared types and constants for the running median unit
`timescale 1ns / 1ps
package rmth_pkg;
	localparam int CAPACITY_DEF = 1024;
	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 33;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture sample
		logic push;      // push value register into selected heap
		logic pop;       // pop top of selected heap into value register
		logic sel_hi;    // 1 selects upper heap
		logic finish;    // compute median
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic busy;      // sift in progress
		logic full;
		logic go_lower;  // sample belongs in lower heap
		logic lo_over;   // lower exceeds upper by two or more
		logic hi_over;   // upper exceeds lower
	} dp_sts_t;
endpackage

### hw/rtl/rmth_datapath.sv
// heap memories, sift engine and median arithmetic
`timescale 1ns / 1ps
module rmth_datapath #(
	parameter int CAPACITY = rmth_pkg::CAPACITY_DEF,
	parameter int DEPTH = CAPACITY / 2 + 1,
	parameter int AW = $clog2(DEPTH + 1),
	parameter int CW = $clog2(CAPACITY + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  rmth_pkg::dp_cmd_t cmd,
	output rmth_pkg::dp_sts_t sts,
	input  logic signed [31:0] sample,
	output logic signed [32:0] median_twice,
	output logic [CW-1:0] count_held
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RD    = 7'b0000010,
		S_CMP   = 7'b0000100,
		S_FET   = 7'b0001000,
		S_RDC   = 7'b0010000,
		S_CMPC  = 7'b0100000,
		S_WR    = 7'b1000000
	} sift_t;

	logic signed [31:0] mem_lo [DEPTH];
	logic signed [31:0] mem_hi [DEPTH];
	logic signed [31:0] top_lo_q, top_hi_q;
	logic [AW-1:0] size_lo_q, size_hi_q;
	logic signed [32:0] median_q;
	logic signed [31:0] val_q, rd_a_q, rd_b_q;
	logic signed [31:0] rd_hold_q;
	logic [AW-1:0] idx_q, lim_q;
	logic hi_q, down_q;
	sift_t st_q;
	logic we;
	logic [AW-1:0] wa;
	logic signed [31:0] wd;
	logic [AW-1:0] ra_a, ra_b;
	logic [AW-1:0] par, lft;

	function automatic logic above(input logic signed [31:0] a, input logic signed [31:0] b,
			input logic hi);
		above = hi ? (a < b) : (a > b);
	endfunction

	assign par = (idx_q - AW'(1)) >> 1;
	assign lft = {idx_q[AW-2:0], 1'b1};

	always_comb begin
		ra_a = idx_q;
		ra_b = par;
		if (down_q) begin
			ra_a = lft;
			ra_b = lft + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			if (hi_q) mem_hi[wa] <= wd;
			else mem_lo[wa] <= wd;
		end
		rd_a_q <= hi_q ? mem_hi[ra_a] : mem_lo[ra_a];
		rd_b_q <= hi_q ? mem_hi[ra_b] : mem_lo[ra_b];
	end

	// write requests: sift writes value at idx or the moved entry
	logic signed [31:0] pick;
	logic [AW-1:0] pick_i;
	always_comb begin
		we = 1'b0;
		wa = idx_q;
		wd = val_q;
		pick = rd_a_q;
		pick_i = lft;
		if (down_q && (lft + AW'(1) < lim_q) && above(rd_b_q, rd_a_q, hi_q)) begin
			pick = rd_b_q;
			pick_i = lft + AW'(1);
		end
		case (st_q)
			S_CMP: begin
				we = 1'b1;
				if (idx_q != '0 && above(val_q, rd_b_q, hi_q)) wd = rd_b_q;
			end
			S_CMPC: begin
				we = 1'b1;
				if (lft < lim_q && lft > idx_q && above(pick, val_q, hi_q)) wd = pick;
			end
			S_WR: we = 1'b1;
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			size_lo_q <= '0;
			size_hi_q <= '0;
			median_q <= '0;
			hi_q <= 1'b0;
			down_q <= 1'b0;
			val_q <= '0;
			rd_hold_q <= '0;
			idx_q <= '0;
			lim_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (cmd.push) begin
						hi_q <= cmd.sel_hi;
						down_q <= 1'b0;
						if (cmd.sel_hi) begin
							idx_q <= size_hi_q;
							size_hi_q <= size_hi_q + AW'(1);
						end else begin
							idx_q <= size_lo_q;
							size_lo_q <= size_lo_q + AW'(1);
						end
						st_q <= S_RD;
					end else if (cmd.pop) begin
						hi_q <= cmd.sel_hi;
						down_q <= 1'b0;
						if (cmd.sel_hi) begin
							val_q <= top_hi_q;
							idx_q <= size_hi_q - AW'(1);
							lim_q <= size_hi_q - AW'(1);
							size_hi_q <= size_hi_q - AW'(1);
						end else begin
							val_q <= top_lo_q;
							idx_q <= size_lo_q - AW'(1);
							lim_q <= size_lo_q - AW'(1);
							size_lo_q <= size_lo_q - AW'(1);
						end
						st_q <= S_FET;
					end else if (cmd.finish) begin
						if (size_lo_q > size_hi_q) median_q <= {top_lo_q, 1'b0};
						else median_q <= 33'(top_lo_q) + 33'(top_hi_q);
					end
					if (cmd.load) val_q <= sample;
				end
				S_RD: st_q <= S_CMP;
				S_CMP: begin
					if (idx_q != '0 && above(val_q, rd_b_q, hi_q)) begin
						idx_q <= par;
						st_q <= S_RD;
					end else begin
						st_q <= S_WR;
					end
				end
				S_FET: st_q <= S_RDC;
				S_RDC: begin
					// first pass through S_RDC on a pop: take last entry, then sift down from root
					if (!down_q) begin
						st_q <= S_RDC;
						down_q <= 1'b1;
						val_q <= rd_a_q;
						// keep popped top for move
						rd_hold_q <= val_q;
						idx_q <= '0;
					end else begin
						st_q <= S_CMPC;
					end
				end
				S_CMPC: begin
					if (lft < lim_q && lft > idx_q && above(pick, val_q, hi_q)) begin
						idx_q <= pick_i;
						st_q <= S_RDC;
					end else begin
						st_q <= S_WR;
					end
				end
				S_WR: begin
					st_q <= S_IDLE;
					if (down_q) val_q <= rd_hold_q;
					down_q <= 1'b0;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// cached heap tops track root writes
	always_ff @(posedge clk) begin
		if (we && wa == '0) begin
			if (hi_q) top_hi_q <= wd;
			else top_lo_q <= wd;
		end
	end

	logic [CW-1:0] cnt;
	assign cnt = CW'(size_lo_q) + CW'(size_hi_q);
	assign sts.busy = (st_q != S_IDLE);
	assign sts.full = (cnt >= CW'(CAPACITY));
	assign sts.go_lower = (size_lo_q == '0) || (val_q <= top_lo_q);
	assign sts.lo_over = (size_lo_q > size_hi_q + AW'(1));
	assign sts.hi_over = (size_hi_q > size_lo_q);
	assign median_twice = median_q;
	assign count_held = cnt;
endmodule

### hw/rtl/rmth_ctrl.sv
// sequencer for insert, rebalance and result handshake
`timescale 1ns / 1ps
module rmth_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic drop,
	output rmth_pkg::dp_cmd_t cmd,
	input  rmth_pkg::dp_sts_t sts
);
	typedef enum logic [6:0] {
		C_IDLE  = 7'b0000001,
		C_INS   = 7'b0000010,
		C_WINS  = 7'b0000100,
		C_POP   = 7'b0001000,
		C_WPOP  = 7'b0010000,
		C_WPSH  = 7'b0100000,
		C_FIN   = 7'b1000000
	} ctrl_t;

	ctrl_t st_q;
	logic side_q, drop_q, ov_q;

	assign in_ready = (st_q == C_IDLE) && (!ov_q || out_ready);
	assign out_valid = ov_q;
	assign drop = drop_q;

	always_comb begin
		cmd = '0;
		case (st_q)
			C_IDLE: cmd.load = in_valid && in_ready;
			C_INS: begin
				cmd.push = !sts.full;
				cmd.sel_hi = !sts.go_lower;
			end
			C_POP: begin
				cmd.pop = sts.lo_over || sts.hi_over;
				cmd.sel_hi = sts.hi_over;
			end
			C_WPOP: begin
				cmd.push = !sts.busy;
				cmd.sel_hi = !side_q;
			end
			C_FIN: cmd.finish = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			side_q <= 1'b0;
			drop_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (st_q)
				C_IDLE: if (in_valid && in_ready) st_q <= C_INS;
				C_INS: begin
					drop_q <= sts.full;
					st_q <= sts.full ? C_FIN : C_WINS;
				end
				C_WINS: if (!sts.busy) st_q <= C_POP;
				C_POP: begin
					side_q <= sts.hi_over;
					st_q <= (sts.lo_over || sts.hi_over) ? C_WPOP : C_FIN;
				end
				C_WPOP: if (!sts.busy) st_q <= C_WPSH;
				C_WPSH: if (!sts.busy) st_q <= C_FIN;
				C_FIN: begin
					ov_q <= 1'b1;
					st_q <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/running_median_two_heaps_unit.sv
// top level of the two-heap running median unit
// one signed 32-bit sample enters on the s_axis channel and one result word
// leaves on the m_axis channel for every sample.
// the result holds twice the running median, the count of samples held
// and a flag set when the store was full and the sample was dropped.
// an item that is not dropped takes one insert sift and at most one pop
// and one push sift; an insert or push walks up a heap memory and a pop
// walks down it, each through a read state and a compare state per level.
// the one sift engine is shared by both heap memories, so the sifts of an
// item run one after another, and a new sample is not taken while the last
// one is still being handled.
// the result register holds its word while m_axis_tready is low; the next
// sample is taken as soon as the result is taken or in the same cycle.
// reset clears both heap sizes, the median and all handshake state; the
// heap memories need no clearing.
`timescale 1ns / 1ps
module running_median_two_heaps_unit #(
	parameter int CAPACITY = rmth_pkg::CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // sample
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [47:0] m_axis_tdata    // median_twice, count_held, dropped
);
	localparam int CW = $clog2(CAPACITY + 1);
	rmth_pkg::dp_cmd_t cmd;
	rmth_pkg::dp_sts_t sts;
	logic signed [32:0] med;
	logic [CW-1:0] cnt;
	logic drop;

	rmth_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.drop, .cmd, .sts
	);

	rmth_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.sample(s_axis_tdata), .median_twice(med), .count_held(cnt)
	);

	assign m_axis_tdata = {3'b000, drop, 11'(cnt), med};
endmodule

### hw/rtl/rmth_checker.sv
// port checker for the running median unit
`timescale 1ns / 1ps
module rmth_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [47:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second sample taken before first finished");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[47:45] == 3'b000)
		else $error("padding bits set");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[44] |-> m_axis_tdata[43:33] != 11'd0)
		else $error("dropped with empty store");
endmodule

bind running_median_two_heaps_unit rmth_checker u_chk (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
